// ===== sv/mclw_pkg.sv =====
// ----------------------------------------------------------------------------
// mclw_pkg
// Shared types and constants for the motor command link watchdog.
// ----------------------------------------------------------------------------
package mclw_pkg;

   // register indexes on the configuration port
   localparam logic [1:0] CSR_TIMEOUT_TICKS = 2'd0;
   localparam logic [1:0] CSR_COMMAND_CODE  = 2'd1;
   localparam logic [1:0] CSR_PULSES_FULL   = 2'd2;

   // register reset values
   localparam logic [15:0] TIMEOUT_RESET    = 16'd1000;
   localparam logic [7:0]  COMMAND_RESET    = 8'h55;
   localparam logic [7:0]  PULSES_RESET     = 8'd240;

   // item kinds
   localparam logic REQ_PACKET = 1'b0;
   localparam logic REQ_TICK   = 1'b1;

   // packet checks
   localparam logic signed [15:0] SPEED_MIN = -16'sd1000;
   localparam logic signed [15:0] SPEED_MAX =  16'sd1000;
   localparam logic [7:0]  MASK_MIN  = 8'd1;
   localparam logic [7:0]  MASK_MAX  = 8'd3;

   // watchdog count saturation
   localparam logic [15:0] COUNT_MAX = 16'hFFFF;

   // largest possible target value
   localparam logic [15:0] TARGET_MAX = 16'd65280;

   // target = floor(mag * pulses * 256 / 1000) = floor(32 * p / 125)
   // computed as (p * ceil(2^30 / 125)) >> 25, exact for p below 2^18
   localparam int          PROD_W       = 18;
   localparam int          RECIP_W      = 24;
   localparam int          SCALE_W      = PROD_W + RECIP_W;
   localparam int          SCALE_SHIFT  = 25;
   localparam logic [RECIP_W-1:0] SCALE_RECIP = 24'd8589935;

   // direction pin codes for one motor: bit0 forward, bit1 reverse
   localparam logic [1:0] PINS_OFF     = 2'b00;
   localparam logic [1:0] PINS_FORWARD = 2'b01;
   localparam logic [1:0] PINS_REVERSE = 2'b10;

   // input beat
   typedef struct packed {
      logic               req_type;
      logic [7:0]         cmd_byte;
      logic [7:0]         motor_mask;
      logic signed [15:0] speed;
   } req_data_type;

   // result beat
   typedef struct packed {
      logic        m1_dir_a;
      logic        m1_dir_b;
      logic        m2_dir_a;
      logic        m2_dir_b;
      logic [15:0] m1_target;
      logic [15:0] m2_target;
      logic        drive_off;
      logic        packet_error;
      logic        in_timeout;
   } rsp_data_type;

   // configuration seen by the datapath
   typedef struct packed {
      logic [15:0] timeout_ticks;
      logic [7:0]  command_code;
      logic [7:0]  pulses_full_speed;
   } cfg_type;

   // decoded item held in the input stage
   typedef struct packed {
      logic              is_tick;
      logic              pkt_ok;
      logic              sel_m1;
      logic              sel_m2;
      logic [1:0]        pins;
      logic [PROD_W-1:0] product;
   } stage_type;

endpackage

// ===== sv/motor_command_link_watchdog_core.sv =====
// ----------------------------------------------------------------------------
// motor_command_link_watchdog_core
// Motor command packet checker with a tick driven link watchdog.
// ----------------------------------------------------------------------------
// an accepted beat enters the input stage, then the result register on advance
// throughput: one beat per cycle unless the output stalls; the state update for
//   an item completes in the single logic pass between the input stage and
//   the result register
// reset: configuration returns to its defaults, count, timeout, pins and
//   targets clear, both stages empty
module motor_command_link_watchdog_core import mclw_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_data_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_data_type rsp_data,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [15:0]  csr_wdata
);

   cfg_type      cfg;
   stage_type    dec;
   stage_type    stage_ff;
   rsp_data_type rsp_next;
   rsp_data_type out_ff;
   logic         stage_valid_ff, stage_valid_in;
   logic         out_valid_ff,   out_valid_in;
   logic         advance;
   logic         req_accept;

   mclw_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   mclw_decode u_decode (
      .req (req_data),
      .cfg (cfg),
      .dec (dec)
   );

   mclw_state u_state (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .stage   (stage_ff),
      .cfg     (cfg),
      .rsp     (rsp_next)
   );

   // pipeline handshake
   assign advance    = stage_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall  = stage_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (req_accept) begin
         stage_valid_in = 1'b1;
      end else if (advance) begin
         stage_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   // input stage and result register payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         stage_ff <= dec;
      end
      if (advance) begin
         out_ff <= rsp_next;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   // shutdown beat always reports the timeout state
   a_drive_off_timeout: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.drive_off |-> rsp_data.in_timeout)
      else $error("drive_off without timeout");

   // a beat is either a shutdown or a packet error, never both
   a_off_err_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.drive_off && rsp_data.packet_error))
      else $error("drive_off and packet_error together");

   // a motor never has both direction pins set
   a_pins_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.m1_dir_a && rsp_data.m1_dir_b) &&
                    !(rsp_data.m2_dir_a && rsp_data.m2_dir_b))
      else $error("both direction pins set");

   // targets stay within the full scale value
   a_target_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.m1_target <= TARGET_MAX) &&
                    (rsp_data.m2_target <= TARGET_MAX))
      else $error("target above full scale");

   // input stalls only while the stage holds a beat that cannot move
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> stage_valid_ff && out_valid_ff && rsp_stall)
      else $error("input stalled without cause");

endmodule

// ===== sv/mclw_csr.sv =====
// ----------------------------------------------------------------------------
// mclw_csr
// Configuration registers, written through a plain write port.
// ----------------------------------------------------------------------------
module mclw_csr import mclw_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   output cfg_type     cfg
);

   logic [15:0] timeout_ff, timeout_in;
   logic [7:0]  command_ff, command_in;
   logic [7:0]  pulses_ff,  pulses_in;

   // register write decode, unknown indexes ignored
   always_comb begin
      timeout_in = timeout_ff;
      command_in = command_ff;
      pulses_in  = pulses_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_TIMEOUT_TICKS: timeout_in = csr_wdata;
            CSR_COMMAND_CODE:  command_in = csr_wdata[7:0];
            CSR_PULSES_FULL:   pulses_in  = csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
         command_ff <= COMMAND_RESET;
         pulses_ff  <= PULSES_RESET;
      end else begin
         timeout_ff <= timeout_in;
         command_ff <= command_in;
         pulses_ff  <= pulses_in;
      end
   end

   assign cfg.timeout_ticks     = timeout_ff;
   assign cfg.command_code      = command_ff;
   assign cfg.pulses_full_speed = pulses_ff;

endmodule

// ===== sv/mclw_decode.sv =====
// ----------------------------------------------------------------------------
// mclw_decode
// Checks an incoming packet and forms the raw speed product for the target.
// ----------------------------------------------------------------------------
module mclw_decode import mclw_pkg::*; (
   input  req_data_type req,
   input  cfg_type      cfg,
   output stage_type    dec
);

   logic [15:0] speed_abs;
   logic [9:0]  mag;
   logic        cmd_ok;
   logic        mask_ok;
   logic        speed_ok;

   // packet validity
   assign cmd_ok   = (req.cmd_byte == cfg.command_code);
   assign mask_ok  = (req.motor_mask >= MASK_MIN) && (req.motor_mask <= MASK_MAX);
   assign speed_ok = (req.speed >= SPEED_MIN) && (req.speed <= SPEED_MAX);

   // magnitude fits ten bits whenever the speed passes the range check
   assign speed_abs = req.speed[15] ? (16'd0 - req.speed) : req.speed;
   assign mag       = speed_abs[9:0];

   // direction pins from the sign
   always_comb begin
      if (req.speed[15]) begin
         dec.pins = PINS_REVERSE;
      end else if (req.speed != 16'sd0) begin
         dec.pins = PINS_FORWARD;
      end else begin
         dec.pins = PINS_OFF;
      end
   end

   assign dec.is_tick = (req.req_type == REQ_TICK);
   assign dec.pkt_ok  = cmd_ok && mask_ok && speed_ok;
   assign dec.sel_m1  = req.motor_mask[0];
   assign dec.sel_m2  = req.motor_mask[1];
   assign dec.product = PROD_W'(mag) * PROD_W'(cfg.pulses_full_speed);

endmodule

// ===== sv/mclw_state.sv =====
// ----------------------------------------------------------------------------
// mclw_state
// Watchdog count, timeout flag, direction pins and targets; builds the result.
// ----------------------------------------------------------------------------
module mclw_state import mclw_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         advance,
   input  stage_type    stage,
   input  cfg_type      cfg,
   output rsp_data_type rsp
);

   logic [15:0]        count_ff,   count_in;
   logic               timeout_ff, timeout_in;
   logic [3:0]         pins_ff,    pins_in;
   logic [15:0]        tgt1_ff,    tgt1_in;
   logic [15:0]        tgt2_ff,    tgt2_in;
   logic [15:0]        count_inc;
   logic [SCALE_W-1:0] scaled;
   logic [15:0]        target;
   logic               drive_off;
   logic               pkt_err;

   // divide by 125 through the reciprocal
   assign scaled = SCALE_W'(stage.product) * SCALE_W'(SCALE_RECIP);
   assign target = scaled[SCALE_SHIFT +: 16];

   // saturating tick count
   assign count_inc = (count_ff == COUNT_MAX) ? count_ff : count_ff + 16'd1;

   // next state for the item in the stage
   always_comb begin
      count_in   = count_ff;
      timeout_in = timeout_ff;
      pins_in    = pins_ff;
      tgt1_in    = tgt1_ff;
      tgt2_in    = tgt2_ff;
      drive_off  = 1'b0;
      pkt_err    = 1'b0;
      if (stage.is_tick) begin
         count_in = count_inc;
         if (!timeout_ff && (count_inc >= cfg.timeout_ticks)) begin
            timeout_in = 1'b1;
            count_in   = 16'd0;
            pins_in    = 4'd0;
            tgt1_in    = 16'd0;
            tgt2_in    = 16'd0;
            drive_off  = 1'b1;
         end
      end else begin
         timeout_in = 1'b0;
         count_in   = 16'd0;
         if (!stage.pkt_ok) begin
            pkt_err = 1'b1;
         end else begin
            if (stage.sel_m1) begin
               tgt1_in      = target;
               pins_in[1:0] = stage.pins;
            end
            if (stage.sel_m2) begin
               tgt2_in      = target;
               pins_in[3:2] = stage.pins;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= 16'd0;
         timeout_ff <= 1'b0;
         pins_ff    <= 4'd0;
         tgt1_ff    <= 16'd0;
         tgt2_ff    <= 16'd0;
      end else if (advance) begin
         count_ff   <= count_in;
         timeout_ff <= timeout_in;
         pins_ff    <= pins_in;
         tgt1_ff    <= tgt1_in;
         tgt2_ff    <= tgt2_in;
      end
   end

   // result fields reflect the state after this item
   assign rsp.m1_dir_a     = pins_in[0];
   assign rsp.m1_dir_b     = pins_in[1];
   assign rsp.m2_dir_a     = pins_in[2];
   assign rsp.m2_dir_b     = pins_in[3];
   assign rsp.m1_target    = tgt1_in;
   assign rsp.m2_target    = tgt2_in;
   assign rsp.drive_off    = drive_off;
   assign rsp.packet_error = pkt_err;
   assign rsp.in_timeout   = timeout_in;

endmodule
